// ===== src/tbfd_pkg.sv =====
// Shared types, constants and codes for the two-byte-header frame deframer.
package tbfd_pkg;

  // Frame length in bytes, header included (3 to 64)
  localparam int unsigned FRAME_BYTES = 16;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;
  localparam logic [15:0] TALLY_MAX         = 16'hFFFF;

  // Configuration register indexes
  localparam logic [7:0] REG_HEADER_FIRST  = 8'd0;
  localparam logic [7:0] REG_HEADER_SECOND = 8'd1;

  typedef enum logic [1:0] {
    KIND_NONE       = 2'd0,
    KIND_BAD_HEADER = 2'd1,
    KIND_FRAME_BYTE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OP_QUIET = 2'd0,
    OP_BAD   = 2'd1,
    OP_FRAME = 2'd2
  } op_e;

  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_FRAME = 1'b1
  } back_state_e;

  typedef struct packed {
    logic       line_error;
    logic [7:0] rx_data;
    logic       clear_count;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  frame_byte;
    logic [5:0]  byte_position;
    logic        last;
    logic [15:0] error_total;
  } out_item_t;

  typedef struct packed {
    logic [7:0] index;
    logic [7:0] value;
  } cfg_write_t;

  // Command from the front part to the back part
  typedef struct packed {
    op_e              op;
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;
    logic [7:0]       wr_byte;
    logic [15:0]      total;
  } cmd_t;

endpackage

// ===== src/tbfd_if.sv =====
// Valid/ready channel interfaces for input requests, results and config writes.
interface tbfd_in_if;
  logic               valid;
  logic               ready;
  tbfd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tbfd_out_if;
  logic                valid;
  logic                ready;
  tbfd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tbfd_cfg_if;
  logic                 valid;
  logic                 ready;
  tbfd_pkg::cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/tbfd_front.sv =====
// Front part: header hunt, frame fill count, error tally and command build.
module tbfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tbfd_in_if.sink           in_i,
  tbfd_cfg_if.sink          cfg_i,
  output tbfd_pkg::cmd_t    cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);
  import tbfd_pkg::*;

  logic [7:0]       hdr_first_q, hdr_second_q;
  phase_e           phase_q, phase_d;
  logic [POS_W-1:0] fill_q, fill_d;
  logic [15:0]      tally_q, tally_d, tally_inc;
  logic [POS_W:0]   fill_inc;
  logic             frame_done;
  logic             accept;
  in_item_t         req;

  assign req         = in_i.data;
  assign accept      = in_i.valid && cmd_ready_i;
  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign cfg_i.ready = 1'b1;

  // Count of frame bytes, header included, held once this byte is stored
  assign fill_inc   = {1'b0, fill_q} + (POS_W+1)'(1);
  assign frame_done = (fill_inc == (POS_W+1)'(FRAME_BYTES));

  // Saturating error count including this request's line error
  assign tally_inc = (req.line_error && (tally_q != TALLY_MAX)) ? tally_q + 16'd1 : tally_q;

  // Next parse state
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    if (req.line_error) begin
      phase_d = PH_HUNT;
      fill_d  = '0;
    end else begin
      unique case (phase_q)
        PH_HUNT: begin
          if (req.rx_data == hdr_first_q) begin
            phase_d = PH_SECOND;
            fill_d  = POS_W'(1);
          end
        end
        PH_SECOND: begin
          if (req.rx_data == hdr_second_q) begin
            phase_d = PH_BODY;
            fill_d  = POS_W'(2);
          end else if (req.rx_data != hdr_first_q) begin
            phase_d = PH_HUNT;
            fill_d  = '0;
          end
        end
        default: begin
          if (frame_done) begin
            phase_d = PH_HUNT;
            fill_d  = '0;
          end else begin
            fill_d = fill_inc[POS_W-1:0];
          end
        end
      endcase
    end
  end

  // Command for the back part
  always_comb begin
    cmd_o.op      = OP_QUIET;
    cmd_o.wr_en   = 1'b0;
    cmd_o.wr_addr = '0;
    cmd_o.wr_byte = req.rx_data;
    cmd_o.total   = tally_inc;
    if (!req.line_error) begin
      unique case (phase_q)
        PH_HUNT: begin
          cmd_o.wr_en = (req.rx_data == hdr_first_q);
        end
        PH_SECOND: begin
          if (req.rx_data == hdr_second_q) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_addr = POS_W'(1);
          end else if (req.rx_data == hdr_first_q) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.op = OP_BAD;
          end
        end
        default: begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = fill_q;
          if (frame_done) cmd_o.op = OP_FRAME;
        end
      endcase
    end
  end

  // Clear the tally after the report when asked
  assign tally_d = req.clear_count ? 16'd0 : tally_inc;

  // Advance parse state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      fill_q  <= '0;
      tally_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      tally_q <= tally_d;
    end
  end

  // Hold header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HEADER_FIRST_RST;
      hdr_second_q <= HEADER_SECOND_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.index == REG_HEADER_FIRST)  hdr_first_q  <= cfg_i.data.value;
      if (cfg_i.data.index == REG_HEADER_SECOND) hdr_second_q <= cfg_i.data.value;
    end
  end

endmodule

// ===== src/tbfd_cmd_fifo.sv =====
// Two-entry command queue between the front and back parts.
module tbfd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tbfd_pkg::cmd_t push_cmd_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output tbfd_pkg::cmd_t pop_cmd_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);
  import tbfd_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

// ===== src/tbfd_back.sv =====
// Back part: frame store, result sequencer and output register.
module tbfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tbfd_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  tbfd_out_if.source     out_o
);
  import tbfd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [7:0]       store_mem [FRAME_BYTES];
  logic [7:0]       rdata_q;
  back_state_e      state_q, state_d;
  logic [POS_W-1:0] idx_q, idx_d;
  logic [15:0]      total_q;
  out_item_t        out_q, out_d;
  logic             out_valid_q;
  logic             slot_free, pop, load;

  assign slot_free   = !out_valid_q || out_o.ready;
  assign pop         = (state_q == BK_IDLE) && cmd_valid_i && slot_free;
  assign cmd_ready_o = (state_q == BK_IDLE) && slot_free;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Next sequencer state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (pop && (cmd_i.op == OP_FRAME)) state_d = BK_FRAME;
      BK_FRAME: if (slot_free && (idx_q == LAST_POS)) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Result build and read index
  always_comb begin
    load  = 1'b0;
    idx_d = idx_q;
    out_d.kind          = KIND_NONE;
    out_d.frame_byte    = 8'd0;
    out_d.byte_position = 6'd0;
    out_d.last          = 1'b1;
    out_d.error_total   = cmd_i.total;
    unique case (state_q)
      BK_IDLE: begin
        idx_d = '0;
        if (pop && (cmd_i.op != OP_FRAME)) begin
          load = 1'b1;
          if (cmd_i.op == OP_BAD) out_d.kind = KIND_BAD_HEADER;
        end
      end
      BK_FRAME: begin
        out_d.kind          = KIND_FRAME_BYTE;
        out_d.frame_byte    = rdata_q;
        out_d.byte_position = 6'(idx_q);
        out_d.last          = (idx_q == LAST_POS);
        out_d.error_total   = total_q;
        if (slot_free) begin
          load  = 1'b1;
          idx_d = idx_q + POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Write frame bytes; read ahead so the data matches the current index
  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.wr_en) store_mem[cmd_i.wr_addr] <= cmd_i.wr_byte;
    rdata_q <= store_mem[idx_d];
  end

  // Hold the report count for the frame run
  always_ff @(posedge clk_i) begin
    if (pop) total_q <= cmd_i.total;
    if (load) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load)             out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== src/two_byte_header_frame_deframer_unit.sv =====
// Top level of the two-byte-header frame deframer.
//
//  channel  dir  payload                                               handshake
//  in_i     in   line_error, rx_data, clear_count                      valid/ready
//  out_o    out  kind, frame_byte, byte_position, last, error_total    valid/ready
//  cfg_i    in   index, value (0 header_first, 1 header_second)        valid/ready
//
// A request is taken by the front part and leaves a command in a
// two-entry queue; the back part turns it into one result, or into FRAME_BYTES
// results at one a cycle while the output register is not stalled, read from
// the frame store. Requests stall only when the queue is full.
// Results wait in an output register while the next request is accepted.
// Reset clears parse state, error count, queue and output valid; headers reload
// 170 and 85. Config writes complete in the cycle they are presented.
module two_byte_header_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbfd_in_if.sink     in_i,
  tbfd_out_if.source  out_o,
  tbfd_cfg_if.sink    cfg_i
);
  import tbfd_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;

  tbfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  tbfd_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_cmd_i   (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_cmd_o    (back_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  tbfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

  // A frame byte is last exactly at the final position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.data.kind == KIND_FRAME_BYTE)) |->
    (out_o.data.last == (out_o.data.byte_position == 6'(FRAME_BYTES - 1))))
    else $error("frame byte last flag does not match position");

  // Non-frame results are single, last and carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.data.kind != KIND_FRAME_BYTE)) |->
    (out_o.data.last && (out_o.data.frame_byte == 8'd0) && (out_o.data.byte_position == 6'd0)))
    else $error("non-frame result malformed");

  // The error count stays the same across one frame run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && (out_o.data.kind == KIND_FRAME_BYTE) && !out_o.data.last)
    |=> $stable(out_o.data.error_total))
    else $error("error count changed inside a frame run");

endmodule
